// ----- hw/rtl/sriex_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sriex_pkg
// Shared types and constants for the small RISC instruction executor.
// ----------------------------------------------------------------------------
package sriex_pkg;

    localparam logic [31:0] PC_RESET = 32'h4000_0000;
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [31:0] INT_CAUSE = 32'd4;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        RUN_OK   = 2'd0,
        RUN_HALT = 2'd1,
        RUN_BAD  = 2'd2
    } run_t;

    typedef enum logic [3:0] {
        OP_HALT  = 4'd0,
        OP_INT   = 4'd1,
        OP_CALL  = 4'd2,
        OP_JUMP  = 4'd3,
        OP_XCHG  = 4'd4,
        OP_ARITH = 4'd5,
        OP_LOGIC = 4'd6,
        OP_SHIFT = 4'd7,
        OP_STORE = 4'd8,
        OP_LOAD  = 4'd9
    } op_t;

    // ALU operations of the shared unit
    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_MUL, ALU_NOT, ALU_AND, ALU_OR, ALU_XOR,
        ALU_SHL, ALU_SAR
    } alu_op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RESP, ST_FETCH, ST_DECODE, ST_EXEC, ST_ADDR2, ST_RD,
        ST_RDDONE, ST_WR, ST_DIV, ST_DIVEND, ST_PUSH2, ST_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sriex_alu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sriex_alu
// Shared combinational unit: add, subtract, multiply, logic and shifts.
// ----------------------------------------------------------------------------
module sriex_alu (
    input  wire sriex_pkg::alu_op_t op,
    input  wire logic [31:0]        a,
    input  wire logic [31:0]        b,
    output logic [31:0]             y
);
    import sriex_pkg::*;

    logic big;
    assign big = |b[31:5];

    always_comb begin
        case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            ALU_MUL: y = a * b;
            ALU_NOT: y = ~a;
            ALU_AND: y = a & b;
            ALU_OR:  y = a | b;
            ALU_XOR: y = a ^ b;
            ALU_SHL: y = big ? 32'd0 : (a << b[4:0]);
            ALU_SAR: y = big ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
            default: y = a;
        endcase
    end
endmodule
`default_nettype wire

// ----- hw/rtl/sriex_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sriex_div
// Signed 32-bit divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sriex_div (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sriex_pkg::div_req_t req,
    output sriex_pkg::div_rsp_t      rsp
);
    import sriex_pkg::*;

    logic [31:0] rem_reg, rem_next, quo_reg, quo_next, dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next, zero_reg, zero_next, busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [31:0] ua, ub;

    assign ua = req.dividend[31] ? -req.dividend : req.dividend;
    assign ub = req.divisor[31] ? -req.divisor : req.divisor;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    always_comb begin
        rem_next = rem_reg; quo_next = quo_reg; dvs_next = dvs_reg;
        cnt_next = cnt_reg; neg_next = neg_reg; zero_next = zero_reg;
        busy_next = busy_reg; done_next = 1'b0;
        if (req.start) begin
            rem_next = '0; quo_next = ua; dvs_next = ub; cnt_next = 6'd32;
            neg_next = req.dividend[31] ^ req.divisor[31];
            zero_next = (req.divisor == '0);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[32]) begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end else begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next; quo_reg <= quo_next; dvs_reg <= dvs_next;
        neg_reg <= neg_next; zero_reg <= zero_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quotient = zero_reg ? 32'hFFFF_FFFF : (neg_reg ? -quo_reg : quo_reg);
endmodule
`default_nettype wire

// ----- hw/rtl/small_risc_instruction_executor_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// small_risc_instruction_executor_top
// 32-bit core with byte memory, driven one transaction at a time.
//
// s_ channel: cmd, mem_address, mem_byte, reg_select. m_ channel: run_status,
// program_counter, read_value, one result per input transaction.
// A write or read, or a step while stopped, goes through ST_DONE to ST_RESP,
// where the result is valid. A step fetches the instruction byte-serially,
// then decodes and executes it; memory words are written and read one byte
// per cycle, and a divide waits for the divider to finish. s_ready is high
// only when the core is idle.
// After reset all 2^MEM_ADDR_BITS bytes of memory are swept to zero, with
// s_ready low. A stalled m_ channel holds its result and keeps s_ready low.
// ----------------------------------------------------------------------------
module small_risc_instruction_executor_top #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [31:0] s_mem_address,
    input  wire logic [7:0]  s_mem_byte,
    input  wire logic [4:0]  s_reg_select,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_run_status,
    output logic [31:0]      m_program_counter,
    output logic [31:0]      m_read_value
);
    import sriex_pkg::*;

    localparam int MemDepth = 1 << MEM_ADDR_BITS;

    logic [7:0] mem [MemDepth];
    logic [7:0] rdata_reg;
    logic                     we;
    logic [MEM_ADDR_BITS-1:0] waddr, raddr;
    logic [7:0]               wdata;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    logic [31:0] gpr_reg [16];
    logic [31:0] gpr_next [16];
    logic [31:0] ctl_reg [3];
    logic [31:0] ctl_next [3];
    state_t      state_reg, state_next;
    logic [1:0]  stop_reg, stop_next;
    logic        clr_reg, clr_next;
    logic [MEM_ADDR_BITS:0] clr_cnt_reg, clr_cnt_next;
    logic [31:0] ir_reg, ir_next, addr_reg, addr_next, data_reg, data_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  bcnt_reg, bcnt_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] rv_reg, rv_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [31:0] maddr_reg, maddr_next;
    logic [7:0]  mbyte_reg, mbyte_next;
    logic [4:0]  sel_reg, sel_next;

    alu_op_t     alu_op;
    logic [31:0] alu_a, alu_b, alu_y;
    div_req_t    dreq;
    div_rsp_t    drsp;

    sriex_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y));
    sriex_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // decoded fields
    logic [3:0]  op, mode, ra, rb, rc;
    logic [31:0] disp, ga, gb, gc;
    logic        take;
    assign op   = ir_reg[7:4];
    assign mode = ir_reg[3:0];
    assign ra   = ir_reg[15:12];
    assign rb   = ir_reg[11:8];
    assign rc   = ir_reg[23:20];
    assign disp = {{20{ir_reg[19]}}, ir_reg[19:16], ir_reg[31:24]};
    assign ga   = gpr_reg[ra];
    assign gb   = gpr_reg[rb];
    assign gc   = gpr_reg[rc];

    always_comb begin
        case (mode[1:0])
            2'd0:    take = 1'b1;
            2'd1:    take = (gb == gc);
            2'd2:    take = (gb != gc);
            default: take = ((gb ^ SIGN_BIT) > (gc ^ SIGN_BIT));
        endcase
    end

    // Memory operation kinds after address computation
    // phase: what to do after a word read completes (the word is in acc)
    localparam logic [1:0] PH_NONE = 2'd0, PH_PC = 2'd1, PH_GA = 2'd2, PH_CA = 2'd3;

    always_comb begin
        logic [31:0] rd_word;
        state_next = state_reg;
        stop_next = stop_reg; clr_next = clr_reg; clr_cnt_next = clr_cnt_reg;
        ir_next = ir_reg; addr_next = addr_reg; data_next = data_reg;
        acc_next = acc_reg; bcnt_next = bcnt_reg; phase_next = phase_reg;
        rv_next = rv_reg; cmd_next = cmd_reg; maddr_next = maddr_reg;
        mbyte_next = mbyte_reg; sel_next = sel_reg;
        for (int i = 0; i < 16; i++) gpr_next[i] = gpr_reg[i];
        for (int i = 0; i < 3; i++) ctl_next[i] = ctl_reg[i];
        we = 1'b0; waddr = maddr_reg[MEM_ADDR_BITS-1:0]; wdata = mbyte_reg;
        raddr = addr_reg[MEM_ADDR_BITS-1:0];
        alu_op = ALU_ADD; alu_a = '0; alu_b = '0;
        dreq.start = 1'b0; dreq.dividend = gb; dreq.divisor = gc;
        s_ready = 1'b0; m_valid = 1'b0;
        rd_word = {rdata_reg, acc_reg[31:8]};

        if (clr_reg) begin
            we = 1'b1;
            waddr = clr_cnt_reg[MEM_ADDR_BITS-1:0];
            wdata = '0;
            clr_cnt_next = clr_cnt_reg + {{MEM_ADDR_BITS{1'b0}}, 1'b1};
            if (clr_cnt_reg[MEM_ADDR_BITS-1:0] == '1) clr_next = 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        cmd_next = s_cmd; maddr_next = s_mem_address;
                        mbyte_next = s_mem_byte; sel_next = s_reg_select;
                        rv_next = '0;
                        state_next = ST_DONE;
                        if (s_cmd == CMD_STEP && stop_reg == RUN_OK) begin
                            addr_next = gpr_reg[15];
                            bcnt_next = '0;
                            state_next = ST_FETCH;
                        end
                    end
                end
                ST_DONE: begin
                    if (cmd_reg == CMD_WRITE) we = 1'b1;
                    if (cmd_reg == CMD_READ) begin
                        if (sel_reg < 5'd16) rv_next = gpr_reg[sel_reg[3:0]];
                        else if (sel_reg < 5'd19) rv_next = ctl_reg[2'(sel_reg - 5'd16)];
                    end
                    state_next = ST_RESP;
                end
                ST_RESP: begin
                    m_valid = 1'b1;
                    if (m_ready) state_next = ST_IDLE;
                end
                ST_FETCH: begin
                    // byte read pipelined: address bcnt issued, data next cycle
                    raddr = MEM_ADDR_BITS'(gpr_reg[15] + 32'(bcnt_reg[1:0]));
                    if (bcnt_reg != 3'd0) acc_next = rd_word;
                    bcnt_next = bcnt_reg + 3'd1;
                    if (bcnt_reg == 3'd4) begin
                        ir_next = rd_word;
                        gpr_next[15] = gpr_reg[15] + 32'd4;
                        state_next = ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    state_next = ST_RESP;
                    bcnt_next = '0;
                    phase_next = PH_NONE;
                    case (op)
                        OP_HALT: stop_next = RUN_HALT;
                        OP_INT: begin
                            alu_op = ALU_SUB; alu_a = gpr_reg[14]; alu_b = 32'd4;
                            gpr_next[14] = alu_y; addr_next = alu_y;
                            data_next = ctl_reg[0];
                            state_next = ST_WR;
                        end
                        OP_CALL: begin
                            alu_op = ALU_SUB; alu_a = gpr_reg[14]; alu_b = 32'd4;
                            gpr_next[14] = alu_y; addr_next = alu_y;
                            data_next = gpr_reg[15];
                            state_next = ST_WR;
                        end
                        OP_JUMP: begin
                            if (mode < 4'd8 && take) begin
                                alu_op = ALU_ADD; alu_a = ga; alu_b = disp;
                                if (mode < 4'd4) gpr_next[15] = alu_y;
                                else begin
                                    acc_next = alu_y; phase_next = PH_PC;
                                    state_next = ST_ADDR2;
                                end
                            end
                        end
                        OP_XCHG: begin
                            gpr_next[rb] = gc;
                            gpr_next[rc] = gb;
                        end
                        default: state_next = ST_EXEC;
                    endcase
                    // unknown opcode stops the core with nothing executed
                    if (op > 4'd9) begin
                        stop_next = RUN_BAD;
                        state_next = ST_RESP;
                    end
                end
                ST_EXEC: begin
                    state_next = ST_RESP;
                    case (op)
                        OP_ARITH: begin
                            alu_a = gb; alu_b = gc;
                            alu_op = (mode == 4'd1) ? ALU_SUB :
                                     (mode == 4'd2) ? ALU_MUL : ALU_ADD;
                            if (mode < 4'd3) gpr_next[ra] = alu_y;
                            else if (mode == 4'd3) begin
                                dreq.start = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        OP_LOGIC: begin
                            alu_a = gb; alu_b = gc;
                            case (mode)
                                4'd0: alu_op = ALU_NOT;
                                4'd1: alu_op = ALU_AND;
                                4'd2: alu_op = ALU_OR;
                                default: alu_op = ALU_XOR;
                            endcase
                            if (mode < 4'd4) gpr_next[ra] = alu_y;
                        end
                        OP_SHIFT: begin
                            alu_a = gb; alu_b = gc;
                            alu_op = (mode == 4'd0) ? ALU_SHL : ALU_SAR;
                            if (mode < 4'd2) gpr_next[ra] = alu_y;
                        end
                        OP_STORE: begin
                            alu_op = ALU_ADD; alu_a = ga; alu_b = disp;
                            data_next = gc;
                            if (mode == 4'd0) begin
                                acc_next = alu_y; state_next = ST_ADDR2;
                            end else if (mode == 4'd1) begin
                                gpr_next[ra] = alu_y; addr_next = alu_y;
                                // data register is the updated base when rc == ra
                                data_next = (rc == ra) ? alu_y : gc;
                                state_next = ST_WR;
                            end else if (mode == 4'd2) begin
                                acc_next = alu_y; state_next = ST_ADDR2;
                            end
                        end
                        default: begin // load
                            alu_op = ALU_ADD;
                            case (mode)
                                4'd0: gpr_next[ra] = (rb < 4'd3) ? ctl_reg[rb[1:0]] : '0;
                                4'd1: begin
                                    alu_a = gb; alu_b = disp;
                                    gpr_next[ra] = alu_y;
                                end
                                4'd2, 4'd6: begin
                                    alu_a = gpr_reg[0]; alu_b = gb;
                                    acc_next = alu_y;
                                    phase_next = (mode == 4'd2) ? PH_GA : PH_CA;
                                    state_next = ST_ADDR2;
                                end
                                4'd3: begin
                                    alu_a = gpr_reg[0]; alu_b = gb;
                                    acc_next = alu_y;
                                    phase_next = PH_GA;
                                    state_next = ST_ADDR2;
                                end
                                4'd4: if (ra < 4'd3) ctl_next[ra[1:0]] = gb;
                                default: ;
                            endcase
                        end
                    endcase
                end
                ST_ADDR2: begin
                    // final address term; acc holds the partial sum
                    alu_op = ALU_ADD; alu_a = acc_reg;
                    state_next = ST_RD;
                    bcnt_next = '0;
                    case (op)
                        OP_CALL, OP_JUMP: alu_b = gc + disp;
                        OP_STORE: alu_b = (mode == 4'd2) ? gb + gpr_reg[0] : gb;
                        default: alu_b = (mode == 4'd3) ? gpr_reg[0] : gc + disp;
                    endcase
                    addr_next = alu_y;
                    if (op == OP_CALL || op == OP_JUMP) begin
                        // acc was ga + disp; jump/call need ga+gb+gc+disp
                        alu_b = gb + gc;
                        addr_next = alu_y;
                    end
                    if (op == OP_STORE && mode == 4'd0) begin
                        state_next = ST_WR;
                    end
                end
                ST_RD: begin
                    raddr = MEM_ADDR_BITS'(addr_reg + 32'(bcnt_reg[1:0]));
                    if (bcnt_reg != 3'd0) acc_next = rd_word;
                    bcnt_next = bcnt_reg + 3'd1;
                    if (bcnt_reg == 3'd4) state_next = ST_RDDONE;
                end
                ST_RDDONE: begin
                    state_next = ST_RESP;
                    if (op == OP_STORE) begin
                        addr_next = acc_reg; bcnt_next = '0;
                        state_next = ST_WR;
                    end else begin
                        case (phase_reg)
                            PH_PC: gpr_next[15] = acc_reg;
                            PH_GA: begin
                                gpr_next[ra] = acc_reg;
                                // post-increment applies to the loaded value when rb == ra
                                if (mode == 4'd3)
                                    gpr_next[rb] = ((ra == rb) ? acc_reg : gb) + disp;
                            end
                            PH_CA: if (ra < 4'd3) ctl_next[ra[1:0]] = acc_reg;
                            default: ;
                        endcase
                    end
                end
                ST_WR: begin
                    we = 1'b1;
                    waddr = MEM_ADDR_BITS'(addr_reg + 32'(bcnt_reg[1:0]));
                    wdata = data_reg[8*bcnt_reg[1:0] +: 8];
                    bcnt_next = bcnt_reg + 3'd1;
                    if (bcnt_reg == 3'd3) begin
                        bcnt_next = '0;
                        state_next = ST_RESP;
                        if (op == OP_INT) state_next = ST_PUSH2;
                        if (op == OP_CALL) begin
                            if (mode == 4'd0) begin
                                alu_op = ALU_ADD; alu_a = ga; alu_b = gb + disp;
                                gpr_next[15] = alu_y;
                            end else if (mode == 4'd1) begin
                                acc_next = ga + disp; phase_next = PH_PC;
                                state_next = ST_ADDR2;
                            end
                        end
                    end
                end
                ST_PUSH2: begin
                    alu_op = ALU_SUB; alu_a = gpr_reg[14]; alu_b = 32'd4;
                    gpr_next[14] = alu_y; addr_next = alu_y;
                    data_next = gpr_reg[15];
                    ctl_next[2] = INT_CAUSE;
                    ctl_next[0] = ctl_reg[0] & ~32'd1;
                    gpr_next[15] = ctl_reg[1];
                    ir_next[7:4] = OP_CALL; ir_next[3:0] = 4'd15; // plain push
                    state_next = ST_WR;
                end
                ST_DIV: state_next = ST_DIVEND;
                ST_DIVEND: begin
                    if (drsp.done) begin
                        gpr_next[ra] = drsp.quotient;
                        state_next = ST_RESP;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            stop_reg <= RUN_OK;
            clr_reg <= 1'b1;
            clr_cnt_reg <= '0;
            for (int i = 0; i < 16; i++) gpr_reg[i] <= (i == 15) ? PC_RESET : '0;
            for (int i = 0; i < 3; i++) ctl_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            stop_reg <= stop_next;
            clr_reg <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
            for (int i = 0; i < 16; i++) gpr_reg[i] <= gpr_next[i];
            for (int i = 0; i < 3; i++) ctl_reg[i] <= ctl_next[i];
        end
        ir_reg <= ir_next; addr_reg <= addr_next; data_reg <= data_next;
        acc_reg <= acc_next; bcnt_reg <= bcnt_next; phase_reg <= phase_next;
        rv_reg <= rv_next; cmd_reg <= cmd_next; maddr_reg <= maddr_next;
        mbyte_reg <= mbyte_next; sel_reg <= sel_next;
    end

    assign m_run_status = stop_reg;
    assign m_program_counter = gpr_reg[15];
    assign m_read_value = rv_reg;
endmodule
`default_nettype wire
